// ===== design/swfn_pkg.sv =====
// Shared constants and types for the sliding window first negative block.
// No dependencies; compile first.
package swfn_pkg;

	localparam int WINDOW_MAX_DEF   = 256;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int POS_W            = 16;
	localparam int CFG_W            = 9;
	localparam int OUT_W            = 32;

	typedef struct packed {
		logic valid;
		logic none_found;
		logic end_of_sequence;
	} res_flags_t;

endpackage

// ===== design/swfn_if.sv =====
// Valid/ready channel interfaces: sample words in, result words out, config writes.
// Depends on swfn_pkg.
interface swfn_in_if;
	logic                                          valid;
	logic                                          ready;
	logic signed [swfn_pkg::SAMPLE_WIDTH_DEF-1:0] sample;
	logic                                          last_of_sequence;

	modport source(output valid, sample, last_of_sequence, input ready);
	modport sink(input valid, sample, last_of_sequence, output ready);
endinterface

interface swfn_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [swfn_pkg::OUT_W-1:0] first_negative;
	logic                              none_found;
	logic                              end_of_sequence;

	modport source(output valid, first_negative, none_found, end_of_sequence, input ready);
	modport sink(input valid, first_negative, none_found, end_of_sequence, output ready);
endinterface

interface swfn_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [swfn_pkg::CFG_W-1:0] window_size;

	modport source(output valid, window_size, input ready);
	modport sink(input valid, window_size, output ready);
endinterface

// ===== design/swfn_mem.sv =====
// Queue storage: one write port, one read port, registered read data.
// A write to the address being read is forwarded into the read register.
module swfn_mem #(
	parameter int DEPTH = swfn_pkg::WINDOW_MAX_DEF,
	parameter int WIDTH = swfn_pkg::SAMPLE_WIDTH_DEF + swfn_pkg::POS_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/swfn_queue.sv =====
// Negative-sample queue: pointers, count, position counter, cached front entries,
// pop/push decisions and the per-word result. Depends on swfn_pkg and swfn_mem.
module swfn_queue #(
	parameter int WINDOW_MAX   = swfn_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = swfn_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [SAMPLE_WIDTH-1:0]            sample,
	input  logic                               last,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]    win,
	output swfn_pkg::res_flags_t               flags,
	output logic [SAMPLE_WIDTH-1:0]            value
);

	localparam int AW   = $clog2(WINDOW_MAX);
	localparam int CW   = $clog2(WINDOW_MAX + 1);
	localparam int PW   = swfn_pkg::POS_W;
	localparam int ENTW = SAMPLE_WIDTH + PW;
	localparam logic [AW-1:0]   LAST_SLOT = AW'(WINDOW_MAX - 1);
	localparam logic [CW-1:0]   FULL      = CW'(WINDOW_MAX);
	localparam logic [AW+1:0]   DEPTH_X   = (AW+2)'(WINDOW_MAX);

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		return (i == LAST_SLOT) ? '0 : i + 1'b1;
	endfunction

	logic [AW-1:0]   head_q, tail_q, head_n, tail_n, head_ap, rd_addr;
	logic [CW-1:0]   count_q, count_n, count_ap;
	logic [PW-1:0]   pos_q, pos_n, age0, agef, win_p;
	logic            filled_q, filled_n, fill_now;
	logic [ENTW-1:0] e0_q, e1_q, e0_n, e1_n, e2, new_ent, fr;
	logic            pop, push, fr_ok, hit;
	logic [PW:0]     pos_p1;
	logic [AW+1:0]   rd_sum;

	assign win_p   = PW'(win);
	assign new_ent = {sample, pos_q};
	assign age0    = pos_q - e0_q[PW-1:0];
	assign pop     = (count_q != '0) && (age0 >= win_p);
	assign count_ap = count_q - CW'(pop);
	assign push    = sample[SAMPLE_WIDTH-1] && (count_ap != FULL);
	assign head_ap = pop ? next_slot(head_q) : head_q;

	always_comb begin
		if (count_ap != '0) begin
			fr    = pop ? e1_q : e0_q;
			fr_ok = 1'b1;
		end else begin
			fr    = new_ent;
			fr_ok = push;
		end
	end

	assign agef     = pos_q - fr[PW-1:0];
	assign hit      = fr_ok && (agef < win_p);
	assign pos_p1   = {1'b0, pos_q} + 1'b1;
	assign fill_now = filled_q || (pos_p1 >= {1'b0, win_p});

	assign flags.valid           = step && fill_now;
	assign flags.none_found      = !hit;
	assign flags.end_of_sequence = last;
	assign value                 = hit ? fr[ENTW-1:PW] : '0;

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		count_n  = count_q;
		pos_n    = pos_q;
		filled_n = filled_q;
		e0_n     = e0_q;
		e1_n     = e1_q;
		if (step) begin
			head_n   = head_ap;
			tail_n   = push ? next_slot(tail_q) : tail_q;
			count_n  = count_ap + CW'(push);
			pos_n    = pos_p1[PW-1:0];
			filled_n = fill_now;
			e0_n     = pop ? e1_q : e0_q;
			e1_n     = pop ? e2 : e1_q;
			if (push && (count_ap == '0)) begin
				e0_n = new_ent;
			end
			if (push && (count_ap == CW'(1))) begin
				e1_n = new_ent;
			end
			if (last) begin
				head_n   = '0;
				tail_n   = '0;
				count_n  = '0;
				pos_n    = '0;
				filled_n = 1'b0;
			end
		end
	end

	// third entry behind the head is prefetched every cycle
	assign rd_sum  = {2'b00, head_n} + (AW+2)'(2);
	assign rd_addr = (rd_sum >= DEPTH_X) ? AW'(rd_sum - DEPTH_X) : AW'(rd_sum);

	swfn_mem #(
		.DEPTH(WINDOW_MAX),
		.WIDTH(ENTW)
	) u_mem (
		.clk    (clk),
		.wr_en  (step && push),
		.wr_addr(tail_q),
		.wr_data(new_ent),
		.rd_addr(rd_addr),
		.rd_data(e2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			filled_q <= 1'b0;
		end else begin
			head_q   <= head_n;
			tail_q   <= tail_n;
			count_q  <= count_n;
			pos_q    <= pos_n;
			filled_q <= filled_n;
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= e0_n;
		e1_q <= e1_n;
	end

endmodule

// ===== design/sliding_window_first_negative.sv =====
// Reports, for each sample word once the window has filled, the oldest negative sample among
// the last window_size samples (or 0 with none_found set). Takes one sample word per cycle and
// returns its result word through an output register in the next cycle; input stays ready while
// that register is empty or being taken. The rate is set by the queue memory, whose third entry
// behind the head is prefetched every cycle. window_size 0 acts as 1, above WINDOW_MAX as
// WINDOW_MAX; write it only while idle. A word marked last_of_sequence clears the sequence.
// Depends on swfn_pkg, swfn_if, swfn_queue and swfn_mem.
module sliding_window_first_negative #(
	parameter int WINDOW_MAX = swfn_pkg::WINDOW_MAX_DEF
) (
	input logic         clk,
	input logic         arst_n,
	swfn_cfg_if.sink    cfg,
	swfn_in_if.sink     samples,
	swfn_out_if.source  results
);

	localparam int SAMPLE_WIDTH = swfn_pkg::SAMPLE_WIDTH_DEF;
	localparam int EW = $clog2(WINDOW_MAX + 1);
	localparam int PW = swfn_pkg::POS_W;
	localparam logic [PW-1:0] WMAX_P = PW'(WINDOW_MAX);

	logic [EW-1:0]            win_q;
	logic [PW-1:0]            cfg_p, eff_p;
	logic                     step, ov_q;
	swfn_pkg::res_flags_t     flags;
	logic [SAMPLE_WIDTH-1:0]  value, val_q;
	logic                     none_q, eos_q;

	assign cfg.ready = 1'b1;
	assign cfg_p     = PW'(cfg.window_size);
	assign eff_p     = (cfg_p == '0) ? PW'(1) : ((cfg_p > WMAX_P) ? WMAX_P : cfg_p);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= EW'(1);
		end else if (cfg.valid) begin
			win_q <= EW'(eff_p);
		end
	end

	assign samples.ready = !ov_q || results.ready;
	assign step          = samples.valid && samples.ready;

	swfn_queue #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.sample(samples.sample),
		.last  (samples.last_of_sequence),
		.win   (win_q),
		.flags (flags),
		.value (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (step) begin
			ov_q <= flags.valid;
		end else if (results.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && flags.valid) begin
			val_q  <= value;
			none_q <= flags.none_found;
			eos_q  <= flags.end_of_sequence;
		end
	end

	assign results.valid           = ov_q;
	assign results.first_negative  = swfn_pkg::OUT_W'(val_q);
	assign results.none_found      = none_q;
	assign results.end_of_sequence = eos_q;

endmodule
